### src/awb_gain_normalizer_unit_assert.svh
// assertion macros for the white balance gain normalizer
`ifndef AWB_GAIN_NORMALIZER_UNIT_ASSERT_SVH
`define AWB_GAIN_NORMALIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AWBGN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("awbgn: property violated");
`define AWBGN_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("awbgn: implication violated");
`else
`define AWBGN_ASSERT(lbl, prop)
`define AWBGN_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

### src/awbgn_pkg.sv
// shared types and constants for the white balance gain normalizer
package awbgn_pkg;

  localparam int unsigned InBits     = 16;
  localparam int unsigned RatioShift = 9;   // ratio of 1.0 is 512
  localparam int unsigned GainShift  = 8;   // gain of 1.0 is 256
  localparam int unsigned DivABits   = InBits + RatioShift;
  localparam int unsigned DivBBits   = InBits + GainShift;

  localparam logic [InBits-1:0]   GainUnity  = 16'h0100;
  // unity gain times unity ratio, numerator of the green gain
  localparam logic [DivBBits-1:0] UnityRatio = 24'h02_0000;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StZeroOperand = 2'd1,
    StZeroRatio   = 2'd2
  } status_e;

  // item sideband carried through the gain dividers
  typedef struct packed {
    status_e             status;
    logic [InBits-1:0]   rr;
    logic [InBits-1:0]   br;
  } awbgn_mid_t;

endpackage

### src/awbgn_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
module awbgn_div #(
  parameter int unsigned Lanes    = 2,
  parameter int unsigned DvdBits  = 25,
  parameter int unsigned DvsBits  = 16,
  parameter int unsigned SideBits = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [Lanes-1:0][DvdBits-1:0]     dividend_i,
  input  logic [Lanes-1:0][DvsBits-1:0]     divisor_i,
  input  logic [SideBits-1:0]               side_i,
  output logic                              valid_o,
  output logic [Lanes-1:0][DvdBits-1:0]     quotient_o,
  output logic [SideBits-1:0]               side_o
);

  // dq holds the unused dividend bits on top and quotient bits below
  logic [DvdBits:0]                           valid_q;
  logic [DvdBits:0][Lanes-1:0][DvdBits-1:0]   dq_q;
  logic [DvdBits:0][SideBits-1:0]             side_q;
  logic [DvdBits-1:0][Lanes-1:0][DvsBits-1:0] rem_q;
  logic [DvdBits-1:0][Lanes-1:0][DvsBits-1:0] dvs_q;
  logic [DvdBits-1:0][Lanes-1:0][DvsBits-1:0] rem_d;
  logic [DvdBits-1:0][Lanes-1:0][DvdBits-1:0] dq_d;

  for (genvar s = 0; s < DvdBits; s++) begin : g_step
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [DvsBits:0] trial;
      logic [DvsBits:0] diff;
      logic             fits;

      assign trial       = {rem_q[s][l], dq_q[s][l][DvdBits-1]};
      assign diff        = trial - {1'b0, dvs_q[s][l]};
      assign fits        = (trial >= {1'b0, dvs_q[s][l]});
      assign rem_d[s][l] = fits ? diff[DvsBits-1:0] : trial[DvsBits-1:0];
      assign dq_d[s][l]  = {dq_q[s][l][DvdBits-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DvdBits-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      dq_q[0]   <= dividend_i;
      rem_q[0]  <= '0;
      dvs_q[0]  <= divisor_i;
      side_q[0] <= side_i;
    end
    for (int s = 0; s < DvdBits; s++) begin
      if (valid_q[s]) begin
        dq_q[s+1]   <= dq_d[s];
        side_q[s+1] <= side_q[s];
      end
    end
    for (int s = 0; s < DvdBits - 1; s++) begin
      if (valid_q[s]) begin
        rem_q[s+1] <= rem_d[s];
        dvs_q[s+1] <= dvs_q[s];
      end
    end
  end

  assign valid_o    = valid_q[DvdBits];
  assign quotient_o = dq_q[DvdBits];
  assign side_o     = side_q[DvdBits];

endmodule

### src/awb_gain_normalizer_unit.sv
// white balance gain normalizer: golden over measured ratios to rgb gains
// pipeline: 25 ratio divider stages, 24 gain divider stages, input and output registers
// throughput: one item per cycle, busy_o stays low, results cannot stall
// reset: pipeline valid bits and strobe clear, golden ratios return to 512
`include "awb_gain_normalizer_unit_assert.svh"
module awb_gain_normalizer_unit #(
  parameter int unsigned GAIN_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item input
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [awbgn_pkg::InBits-1:0] measured_rg_i,
  input  logic [awbgn_pkg::InBits-1:0] measured_bg_i,
  // result output, one cycle strobe
  output logic                       result_valid_o,
  output logic [awbgn_pkg::InBits-1:0] red_gain_o,
  output logic [awbgn_pkg::InBits-1:0] green_gain_o,
  output logic [awbgn_pkg::InBits-1:0] blue_gain_o,
  output logic [1:0]                 status_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  import awbgn_pkg::*;

  // gains are cut to GAIN_BITS; quotients never exceed the divider width
  localparam int unsigned CmpBits = (GAIN_BITS < DivBBits) ? GAIN_BITS : DivBBits;
  localparam logic [DivBBits-1:0] CutMask = DivBBits'((64'd1 << CmpBits) - 64'd1);
  // edges from the accepting edge until the strobe is seen high at a clock edge
  localparam int unsigned Latency = DivABits + DivBBits + 3;

  // ---------------------------------------------------------------------
  // register port: golden_rg at 0x0, golden_bg at 0x4
  // ---------------------------------------------------------------------
  logic [InBits-1:0] golden_rg_q;
  logic [InBits-1:0] golden_bg_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golden_rg_q <= 16'd512;
      golden_bg_q <= 16'd512;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        golden_bg_q <= pwdata[InBits-1:0];
      end else begin
        golden_rg_q <= pwdata[InBits-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2]) begin
      prdata[InBits-1:0] = golden_bg_q;
    end else begin
      prdata[InBits-1:0] = golden_rg_q;
    end
  end

  // fully pipelined, nothing to hold off
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // ratio dividers: golden * 512 / measured, both channels side by side
  // the golden values are sampled at accept, so later writes do not leak in
  // ---------------------------------------------------------------------
  logic                          accept;
  logic [1:0][DivABits-1:0]      div_a_dvd;
  logic [1:0][InBits-1:0]        div_a_dvs;
  logic                          zero_op;
  logic                          div_a_valid;
  logic [1:0][DivABits-1:0]      div_a_quo;
  logic                          div_a_zero_op;

  assign accept    = start_i && !busy_o;
  assign zero_op   = (measured_rg_i == '0) || (measured_bg_i == '0) ||
                     (golden_rg_q == '0) || (golden_bg_q == '0);
  assign div_a_dvd[0] = {golden_rg_q, {RatioShift{1'b0}}};
  assign div_a_dvd[1] = {golden_bg_q, {RatioShift{1'b0}}};
  assign div_a_dvs[0] = measured_rg_i;
  assign div_a_dvs[1] = measured_bg_i;

  awbgn_div #(
    .Lanes    (2),
    .DvdBits  (DivABits),
    .DvsBits  (InBits),
    .SideBits (1)
  ) u_ratio_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .dividend_i (div_a_dvd),
    .divisor_i  (div_a_dvs),
    .side_i     (zero_op),
    .valid_o    (div_a_valid),
    .quotient_o (div_a_quo),
    .side_o     (div_a_zero_op)
  );

  // ---------------------------------------------------------------------
  // gain dividers, four lanes:
  //   0: green over rr   1: blue over rr   2: red over br   3: green over br
  // ratios are cut to 16 bits here, a zero ratio flags the item
  // ---------------------------------------------------------------------
  awbgn_mid_t                    mid_d;
  awbgn_mid_t                    mid_q;
  logic [1:0]                    ratio_zero;
  logic [3:0][DivBBits-1:0]      div_b_dvd;
  logic [3:0][InBits-1:0]        div_b_dvs;
  logic [$bits(awbgn_mid_t)-1:0] div_b_side;
  logic                          div_b_valid;
  logic [3:0][DivBBits-1:0]      div_b_quo;

  assign ratio_zero[0] = (div_a_quo[0][InBits-1:0] == '0);
  assign ratio_zero[1] = (div_a_quo[1][InBits-1:0] == '0);

  always_comb begin
    mid_d.rr = div_a_quo[0][InBits-1:0];
    mid_d.br = div_a_quo[1][InBits-1:0];
    if (div_a_zero_op) begin
      mid_d.status = StZeroOperand;
    end else if (ratio_zero != 2'b00) begin
      mid_d.status = StZeroRatio;
    end else begin
      mid_d.status = StOk;
    end
  end

  assign div_b_dvd[0] = UnityRatio;
  assign div_b_dvd[1] = {mid_d.br, {GainShift{1'b0}}};
  assign div_b_dvd[2] = {mid_d.rr, {GainShift{1'b0}}};
  assign div_b_dvd[3] = UnityRatio;
  assign div_b_dvs[0] = mid_d.rr;
  assign div_b_dvs[1] = mid_d.rr;
  assign div_b_dvs[2] = mid_d.br;
  assign div_b_dvs[3] = mid_d.br;

  awbgn_div #(
    .Lanes    (4),
    .DvdBits  (DivBBits),
    .DvsBits  (InBits),
    .SideBits ($bits(awbgn_mid_t))
  ) u_gain_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (div_a_valid),
    .dividend_i (div_b_dvd),
    .divisor_i  (div_b_dvs),
    .side_i     (mid_d),
    .valid_o    (div_b_valid),
    .quotient_o (div_b_quo),
    .side_o     (div_b_side)
  );

  assign mid_q = div_b_side;

  // ---------------------------------------------------------------------
  // gain selection: smallest gain lands on unity
  // ---------------------------------------------------------------------
  logic [DivBBits-1:0] gr_cut;
  logic [DivBBits-1:0] gb_cut;
  logic [DivBBits-1:0] b_over_r_cut;
  logic [DivBBits-1:0] r_over_b_cut;
  logic [DivBBits-1:0] r_half_cut;
  logic [DivBBits-1:0] b_half_cut;
  logic                rr_hi;
  logic                br_hi;
  logic                use_b_over_r;
  logic [InBits-1:0]   red_d;
  logic [InBits-1:0]   green_d;
  logic [InBits-1:0]   blue_d;

  assign gr_cut       = div_b_quo[0] & CutMask;
  assign b_over_r_cut = div_b_quo[1] & CutMask;
  assign r_over_b_cut = div_b_quo[2] & CutMask;
  assign gb_cut       = div_b_quo[3] & CutMask;
  assign r_half_cut   = DivBBits'(mid_q.rr >> 1) & CutMask;
  assign b_half_cut   = DivBBits'(mid_q.br >> 1) & CutMask;
  // a ratio of at least 512 has a bit set above bit 8
  assign rr_hi        = (mid_q.rr[InBits-1:RatioShift] != '0);
  assign br_hi        = (mid_q.br[InBits-1:RatioShift] != '0);

  always_comb begin
    // both ratios below one: compare the two candidate green gains
    if (rr_hi) begin
      use_b_over_r = 1'b0;
    end else if (br_hi) begin
      use_b_over_r = 1'b1;
    end else begin
      use_b_over_r = (gr_cut >= gb_cut);
    end

    if (mid_q.status != StOk) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (rr_hi && br_hi) begin
      red_d   = r_half_cut[InBits-1:0];
      green_d = GainUnity;
      blue_d  = b_half_cut[InBits-1:0];
    end else if (use_b_over_r) begin
      red_d   = GainUnity;
      green_d = gr_cut[InBits-1:0];
      blue_d  = b_over_r_cut[InBits-1:0];
    end else begin
      red_d   = r_over_b_cut[InBits-1:0];
      green_d = gb_cut[InBits-1:0];
      blue_d  = GainUnity;
    end
  end

  // ---------------------------------------------------------------------
  // output register, strobe lasts one cycle
  // ---------------------------------------------------------------------
  logic              result_valid_q;
  logic [InBits-1:0] red_q;
  logic [InBits-1:0] green_q;
  logic [InBits-1:0] blue_q;
  status_e           status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= div_b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_b_valid) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      status_q <= mid_q.status;
    end
  end

  assign result_valid_o = result_valid_q;
  assign red_gain_o     = red_q;
  assign green_gain_o   = green_q;
  assign blue_gain_o    = blue_q;
  assign status_o       = status_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // every accepted item shows up after the fixed pipeline latency
  `AWBGN_ASSERT_IMPLY(a_latency, accept, ##Latency result_valid_q)
  // an error result carries no gains
  `AWBGN_ASSERT_IMPLY(a_err_zero, result_valid_q && (status_q != StOk),
                      (red_q == '0) && (green_q == '0) && (blue_q == '0))
  // a good result always has one channel at unity
  `AWBGN_ASSERT_IMPLY(a_unity, result_valid_q && (status_q == StOk),
                      (red_q == GainUnity) || (green_q == GainUnity) || (blue_q == GainUnity))

endmodule
